// File: design/lr3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lr3_pkg
// Shared types and constants for the 3D line rasterizer.
// ----------------------------------------------------------------------------
package lr3_pkg;

   localparam int AXES    = 3;
   localparam int AXIS_W  = 2;
   localparam int LEVEL_W = 8;

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } lr3_state_type;

endpackage
`default_nettype wire

// File: design/line_raster_3d.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_raster_3d
// Rasterizes a straight 3D line between two voxel endpoints into a stream
// of points, each carrying the line color.
// ----------------------------------------------------------------------------
// One request transaction holds a start point, an end point and a color. The
// block answers with longest+1 response transactions, where longest is the
// largest axis delta; the last one is the end point and has tlast set. Each
// interpolated coordinate comes out of one shared restoring divider that
// handles one axis at a time and produces one quotient bit per cycle. For each
// point it loads and divides for x, y and z in turn and then emits the point.
// The block takes no new request until the last point sits in the output
// register, which may still wait for the consumer while the next request is
// accepted.
module line_raster_3d #(
   parameter int GRID_SIZE = 4,
   localparam int CW    = $clog2(GRID_SIZE),
   localparam int REQ_W = ((6 * CW + 3 * lr3_pkg::LEVEL_W + 7) / 8) * 8,
   localparam int RSP_W = ((3 * CW + 3 * lr3_pkg::LEVEL_W + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: start_x, start_y, start_z, end_x, end_y, end_z,
   // red_level, green_level, blue_level.
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // Fields from bit 0: point_x, point_y, point_z, out_red, out_green, out_blue.
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tlast
);
   import lr3_pkg::*;

   localparam int QW    = CW + 1;
   localparam int NW    = 2 * CW + 1;
   localparam int CNT_W = $clog2(QW);
   localparam logic [CW-1:0]    LIMIT   = CW'(GRID_SIZE - 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(QW - 1);

   function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v);
      clamp = (v > LIMIT) ? LIMIT : v;
   endfunction

   lr3_state_type state_ff, state_in;

   logic [CW-1:0]      start_ff [AXES];
   logic [CW-1:0]      end_ff   [AXES];
   logic [CW-1:0]      pt_ff    [AXES];
   logic [CW-1:0]      start_in [AXES];
   logic [CW-1:0]      end_in   [AXES];
   logic [CW-1:0]      pt_in    [AXES];
   logic [LEVEL_W-1:0] red_ff, green_ff, blue_ff, red_in, green_in, blue_in;
   logic [CW-1:0]      longest_ff, longest_in;
   logic [CW-1:0]      step_ff, step_in;
   logic [AXIS_W-1:0]  axis_ff, axis_in;
   logic               final_ff, final_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic [QW-1:0]      num_ff, num_in;
   logic [QW-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [CW-1:0]      out_pt_ff [AXES];
   logic [CW-1:0]      out_pt_in [AXES];
   logic [LEVEL_W-1:0] out_red_ff, out_green_ff, out_blue_ff;
   logic [LEVEL_W-1:0] out_red_in, out_green_in, out_blue_in;

   logic [CW-1:0]      delta [AXES];
   logic [CW-1:0]      longest_calc;
   logic [CW-1:0]      ax_a, ax_b, ax_lo, ax_d, ax_mul;
   logic [2*CW-1:0]    product;
   logic [NW-1:0]      numer;
   logic [CW:0]        trial;
   logic               take;
   logic [QW-1:0]      quo_next;
   logic [CW:0]        coord_sum;
   logic [CW-1:0]      step_next;
   logic               out_free;

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         delta[k] = (start_ff[k] < end_ff[k]) ? end_ff[k] - start_ff[k]
                                              : start_ff[k] - end_ff[k];
      end
      longest_calc = delta[0];
      if (delta[1] > longest_calc) begin
         longest_calc = delta[1];
      end
      if (delta[2] > longest_calc) begin
         longest_calc = delta[2];
      end
   end

   // Per-axis operands for the shared divider.
   always_comb begin
      ax_a    = start_ff[axis_ff];
      ax_b    = end_ff[axis_ff];
      ax_lo   = (ax_a < ax_b) ? ax_a : ax_b;
      ax_d    = (ax_a < ax_b) ? ax_b - ax_a : ax_a - ax_b;
      ax_mul  = (ax_a > ax_b) ? longest_ff - step_ff : step_ff;
      product = {{CW{1'b0}}, ax_mul} * {{CW{1'b0}}, ax_d};
      numer   = {product, 1'b0};
      trial   = {rem_ff, num_ff[QW-1]};
      take    = trial >= {1'b0, longest_ff};
      quo_next = {quo_ff[QW-2:0], take};
      coord_sum = {1'b0, ax_lo} + {1'b0, quo_next[QW-1:1]} + {{CW{1'b0}}, quo_next[0]};
      step_next = step_ff + 1'b1;
      out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in   = state_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      pt_in      = pt_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      longest_in = longest_ff;
      step_in    = step_ff;
      axis_in    = axis_ff;
      final_in   = final_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      out_pt_in    = out_pt_ff;
      out_red_in   = out_red_ff;
      out_green_in = out_green_ff;
      out_blue_in  = out_blue_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               for (int k = 0; k < AXES; k++) begin
                  start_in[k] = clamp(req_tdata[k*CW +: CW]);
                  end_in[k]   = clamp(req_tdata[(k+AXES)*CW +: CW]);
               end
               red_in   = req_tdata[6*CW +: LEVEL_W];
               green_in = req_tdata[6*CW+LEVEL_W +: LEVEL_W];
               blue_in  = req_tdata[6*CW+2*LEVEL_W +: LEVEL_W];
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            longest_in = longest_calc;
            step_in    = '0;
            axis_in    = AXIS_X;
            if (longest_calc == '0) begin
               final_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               final_in = 1'b0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rem_in   = numer[NW-1:QW];
            num_in   = numer[QW-1:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in = take ? CW'(trial - {1'b0, longest_ff}) : trial[CW-1:0];
            num_in = {num_ff[QW-2:0], 1'b0};
            quo_in = quo_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_END) begin
               pt_in[axis_ff] = coord_sum[CW-1:0];
               if (axis_ff == AXIS_Z) begin
                  state_in = ST_EMIT;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = final_ff;
               out_pt_in    = final_ff ? end_ff : pt_ff;
               out_red_in   = red_ff;
               out_green_in = green_ff;
               out_blue_in  = blue_ff;
               if (final_ff) begin
                  state_in = ST_IDLE;
               end else if (step_next == longest_ff) begin
                  final_in = 1'b1;
               end else begin
                  step_in  = step_next;
                  axis_in  = AXIS_X;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      end_ff       <= end_in;
      pt_ff        <= pt_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      longest_ff   <= longest_in;
      step_ff      <= step_in;
      axis_ff      <= axis_in;
      final_ff     <= final_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      rsp_last_ff  <= rsp_last_in;
      out_pt_ff    <= out_pt_in;
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
   end

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < AXES; k++) begin
         rsp_tdata[k*CW +: CW] = out_pt_ff[k];
      end
      rsp_tdata[3*CW +: LEVEL_W]             = out_red_ff;
      rsp_tdata[3*CW+LEVEL_W +: LEVEL_W]     = out_green_ff;
      rsp_tdata[3*CW+2*LEVEL_W +: LEVEL_W]   = out_blue_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// File: sim/line_raster_3d_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_raster_3d_test
// Self-checking testbench for the 3D line rasterizer. A table of directed
// lines covers zero-length lines, full cube diagonals in both directions,
// single-axis lines and color extremes. A random part follows, with some
// zero-length lines. Both sides of the stream stall at random, except during
// one long calm stretch. Every response transaction is checked in order
// against points computed by a local line interpolator or typed into the
// table.
// ----------------------------------------------------------------------------
module line_raster_3d_test;

   localparam int REQ_W        = 40;
   localparam int RSP_W        = 32;
   localparam int COORD_W      = 2;
   localparam int IDLE_PCT     = 26;
   localparam int RANDOM_LINES = 250;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DIR_ROWS     = 20;

   typedef logic [COORD_W-1:0]          coord_type;
   typedef logic [lr3_pkg::LEVEL_W-1:0] level_type;

   typedef struct packed {
      coord_type sx, sy, sz;
      coord_type ex, ey, ez;
      level_type red, green, blue;
   } line_req_type;

   typedef struct packed {
      coord_type x, y, z;
      level_type red, green, blue;
      logic      last;
   } voxel_type;

   // Typed points hold one 12-bit word per point with nibbles x, y, z from the
   // top. An n_typed of zero hands the row to the interpolator.
   typedef struct packed {
      line_req_type     req;
      logic [2:0]       n_typed;
      logic [3:0][11:0] pts;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   voxel_type   voxel_queue[$];
   dir_row_type line_table[DIR_ROWS];
   int          errors = 0;
   int          cycles = 0;
   int          lines_sent = 0;
   int          points_checked = 0;
   int          zero_lines = 0;
   logic        calm = 1'b0;

   line_raster_3d dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d points pending", cycles,
                  voxel_queue.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   function automatic coord_type lerp_axis(input coord_type a, input coord_type b,
                                           input int unsigned step,
                                           input int unsigned longest);
      int unsigned lo, d, mul, q2;
      lo  = (a < b) ? a : b;
      d   = (a < b) ? b - a : a - b;
      mul = (a > b) ? longest - step : step;
      q2  = (mul * d * 2) / longest;
      return coord_type'(lo + (q2 >> 1) + (q2 & 1));
   endfunction

   // Pushes the interpolated points of a line and then its end point.
   function automatic void plot_line(input line_req_type r);
      int unsigned dx, dy, dz, longest;
      voxel_type v;
      dx = (r.sx < r.ex) ? r.ex - r.sx : r.sx - r.ex;
      dy = (r.sy < r.ey) ? r.ey - r.sy : r.sy - r.ey;
      dz = (r.sz < r.ez) ? r.ez - r.sz : r.sz - r.ez;
      longest = dx;
      if (dy > longest) longest = dy;
      if (dz > longest) longest = dz;
      v.red   = r.red;
      v.green = r.green;
      v.blue  = r.blue;
      v.last  = 1'b0;
      for (int unsigned i = 0; i < longest; i++) begin
         v.x = lerp_axis(r.sx, r.ex, i, longest);
         v.y = lerp_axis(r.sy, r.ey, i, longest);
         v.z = lerp_axis(r.sz, r.ez, i, longest);
         voxel_queue.push_back(v);
      end
      v.x    = r.ex;
      v.y    = r.ey;
      v.z    = r.ez;
      v.last = 1'b1;
      voxel_queue.push_back(v);
   endfunction

   task automatic send_line(input line_req_type r, input logic [2:0] n_typed,
                            input logic [3:0][11:0] pts);
      voxel_type v;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, r.blue, r.green, r.red, r.ez, r.ey, r.ex, r.sz, r.sy, r.sx};
      do @(posedge clock); while (!req_tready);
      lines_sent++;
      if (r.sx == r.ex && r.sy == r.ey && r.sz == r.ez) zero_lines++;
      if (n_typed == 0) begin
         plot_line(r);
      end else begin
         for (int k = 0; k < n_typed; k++) begin
            v.x     = coord_type'(pts[k][11:8]);
            v.y     = coord_type'(pts[k][7:4]);
            v.z     = coord_type'(pts[k][3:0]);
            v.red   = r.red;
            v.green = r.green;
            v.blue  = r.blue;
            v.last  = (k == n_typed - 1);
            voxel_queue.push_back(v);
         end
      end
   endtask

   task automatic drain_points;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (voxel_queue.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_side
      voxel_type got, want;
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x     = rsp_tdata[1:0];
         got.y     = rsp_tdata[3:2];
         got.z     = rsp_tdata[5:4];
         got.red   = rsp_tdata[13:6];
         got.green = rsp_tdata[21:14];
         got.blue  = rsp_tdata[29:22];
         got.last  = rsp_tlast;
         if (voxel_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected point (%0d,%0d,%0d)",
                                      got.x, got.y, got.z));
         end else begin
            want = voxel_queue.pop_front();
            points_checked++;
            if (got !== want)
               report_mismatch($sformatf(
                  "point (%0d,%0d,%0d) rgb %h%h%h last %b, expected (%0d,%0d,%0d) rgb %h%h%h last %b",
                  got.x, got.y, got.z, got.red, got.green, got.blue, got.last,
                  want.x, want.y, want.z, want.red, want.green, want.blue, want.last));
         end
      end
   end

   initial begin : stimulus
      line_req_type r;
      logic         zero_len;
      // Rows: start xyz, end xyz, color rgb, typed count, typed points with
      // the last point written first.
      line_table = '{
         '{'{0,0,0, 0,0,0, 8'h00,8'h00,8'h00}, 1, {36'h0, 12'h000}},
         '{'{3,3,3, 3,3,3, 8'hff,8'hff,8'hff}, 1, {36'h0, 12'h333}},
         '{'{1,2,3, 1,2,3, 8'hff,8'h00,8'hff}, 1, {36'h0, 12'h123}},
         '{'{0,0,0, 3,3,3, 8'ha5,8'h5a,8'hc3}, 4, {12'h333,12'h222,12'h111,12'h000}},
         '{'{3,3,3, 0,0,0, 8'h5a,8'ha5,8'h3c}, 4, {12'h000,12'h111,12'h222,12'h333}},
         '{'{0,1,2, 3,1,2, 8'h12,8'h34,8'h56}, 4, {12'h312,12'h212,12'h112,12'h012}},
         '{'{2,3,0, 2,0,0, 8'h80,8'h7f,8'h01}, 4, {12'h200,12'h210,12'h220,12'h230}},
         '{'{1,1,0, 1,1,3, 8'h00,8'hff,8'h00}, 4, {12'h113,12'h112,12'h111,12'h110}},
         '{'{0,0,0, 1,0,0, 8'hff,8'h00,8'h00}, 2, {24'h0, 12'h100, 12'h000}},
         '{'{0,0,0, 3,1,0, 8'h01,8'h80,8'hfe}, 0, 48'h0},
         '{'{3,0,0, 0,2,1, 8'h55,8'haa,8'h55}, 0, 48'h0},
         '{'{1,3,0, 2,0,3, 8'hc0,8'h0c,8'h30}, 0, 48'h0},
         '{'{0,0,0, 2,1,0, 8'h7f,8'h80,8'h7f}, 0, 48'h0},
         '{'{2,1,0, 0,0,0, 8'h0f,8'hf0,8'h0f}, 0, 48'h0},
         '{'{0,3,1, 3,0,2, 8'hde,8'had,8'hbe}, 0, 48'h0},
         '{'{3,0,3, 0,3,0, 8'hef,8'hbe,8'had}, 0, 48'h0},
         '{'{0,2,0, 1,0,3, 8'h11,8'h22,8'h44}, 0, 48'h0},
         '{'{3,1,2, 1,3,3, 8'h88,8'h99,8'hcc}, 0, 48'h0},
         '{'{0,0,3, 3,2,0, 8'h01,8'h02,8'h04}, 0, 48'h0},
         '{'{2,2,2, 3,2,1, 8'hfe,8'hfd,8'hfb}, 0, 48'h0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIR_ROWS; n++)
         send_line(line_table[n].req, line_table[n].n_typed, line_table[n].pts);
      drain_points();

      for (int n = 0; n < RANDOM_LINES; n++) begin
         calm     = (n >= 100 && n < 160);
         zero_len = ($urandom_range(99) < 15);
         r.sx     = coord_type'($urandom_range(3));
         r.sy     = coord_type'($urandom_range(3));
         r.sz     = coord_type'($urandom_range(3));
         r.ex     = zero_len ? r.sx : coord_type'($urandom_range(3));
         r.ey     = zero_len ? r.sy : coord_type'($urandom_range(3));
         r.ez     = zero_len ? r.sz : coord_type'($urandom_range(3));
         r.red    = level_type'($urandom_range(255));
         r.green  = level_type'($urandom_range(255));
         r.blue   = level_type'($urandom_range(255));
         send_line(r, 3'd0, 48'h0);
         if (n == 200) drain_points();
      end
      calm = 1'b0;
      drain_points();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d lines (%0d of zero length), checked %0d points in %0d cycles.",
               lines_sent, zero_lines, points_checked, cycles);
      $display("Random stalls on both sides with one calm stretch; %0d mismatches.",
               errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
